[sv/pdw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdw_pkg
// Shared widths, defaults, register indexes and word types of the
// PC-indexed delta window prefetcher.
// ----------------------------------------------------------------------------
package pdw_pkg;

    localparam int LOG_DEPTH_DEF = 256;
    localparam int ADDR_BITS_DEF = 32;

    localparam int PC_W       = 32;
    localparam int IN_ADDR_W  = 32;
    localparam int OUT_ADDR_W = 32;
    localparam int LIMIT_W    = 32;
    localparam int WD_W       = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = '1;
    localparam logic [WD_W-1:0]    WD_RST    = 8'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_LIMIT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_DISTANCE = 1'b1;

    typedef struct packed {
        logic [PC_W-1:0]      access_pc;
        logic [IN_ADDR_W-1:0] access_addr;
    } t_access_word;

    typedef struct packed {
        logic                  prefetch_valid;
        logic [OUT_ADDR_W-1:0] prefetch_addr;
    } t_prefetch_word;

endpackage

[sv/pc_delta_window_prefetcher_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_delta_window_prefetcher_unit
// PC-indexed delta prefetcher over a shifting log of recent accesses.
// ----------------------------------------------------------------------------
// From acceptance to the next acceptance, when the result is taken at once:
// the log shifts and learns a delta on acceptance, then two registered
// priority-select levels (cell groups, then groups) find the newest ready
// entry with the same pc, and the sum and range check load the output
// register in the cycle a new word may be accepted. A waiting result holds
// the unit until it is taken. The log resets its ready flags at once, so
// there is no clearing pass. Configuration writes land at once.
// ----------------------------------------------------------------------------
module pc_delta_window_prefetcher_unit import pdw_pkg::*; #(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_access_valid,
    output logic                  o_access_ready,
    input  t_access_word          i_access,
    output logic                  o_prefetch_valid,
    input  logic                  i_prefetch_ready,
    output t_prefetch_word        o_prefetch
);

    localparam int IDX_W      = $clog2(LOG_DEPTH);
    localparam int FILL_W     = $clog2(LOG_DEPTH + 1);
    localparam int CMP_W      = (FILL_W > WD_W) ? FILL_W : WD_W;
    localparam int DW         = ADDR_BITS + 1;
    localparam int SW         = ADDR_BITS + 2;
    localparam int CW         = (SW > LIMIT_W + 1) ? SW : LIMIT_W + 1;
    localparam int GROUP_SIZE = (LOG_DEPTH > 256) ? 32 : 16;
    localparam int NUM_GROUPS = (LOG_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_DEPTH  = NUM_GROUPS * GROUP_SIZE;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_GROUP  = 4'b0010,
        S_SELECT = 4'b0100,
        S_SUM    = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [LIMIT_W-1:0]   r_limit;
    logic [WD_W-1:0]      r_wd;
    logic [FILL_W-1:0]    r_fill;
    logic [PC_W-1:0]      r_q_pc;
    logic [ADDR_BITS-1:0] r_q_addr;
    logic                 r_out_valid;
    t_prefetch_word       r_out;

    logic                 w_accept;
    logic                 w_out_load;
    logic [ADDR_BITS-1:0] w_new_addr;
    logic [CMP_W-1:0]     w_wd_ext;
    logic [CMP_W-1:0]     w_fill_ext;
    logic [CMP_W-1:0]     w_wd_m1;
    logic                 w_learn_en;
    logic [IDX_W-1:0]     w_learn_sel;

    logic [PC_W-1:0]      w_pc    [LOG_DEPTH];
    logic [ADDR_BITS-1:0] w_addr  [LOG_DEPTH];
    logic [DW-1:0]        w_dlt   [LOG_DEPTH];
    logic                 w_rdy   [LOG_DEPTH];

    logic [PAD_DEPTH-1:0]           w_hit;
    logic [PAD_DEPTH-1:0][DW-1:0]   w_hit_delta;
    logic [NUM_GROUPS-1:0]          w_grp_hit;
    logic [NUM_GROUPS-1:0][DW-1:0]  w_grp_delta;
    logic                           r_sel_hit;
    logic [DW-1:0]                  r_sel_delta;

    logic signed [SW-1:0] w_sum;
    logic                 w_in_range;
    logic                 w_pf_valid;

    assign w_out_load     = !r_out_valid || i_prefetch_ready;
    assign o_access_ready = (r_state == S_IDLE) || ((r_state == S_SUM) && w_out_load);
    assign w_accept       = i_access_valid && o_access_ready;
    assign w_new_addr     = ADDR_BITS'(i_access.access_addr);

    // learning target is the entry window_distance back, before the shift
    assign w_wd_ext    = CMP_W'(r_wd);
    assign w_fill_ext  = CMP_W'(r_fill);
    assign w_wd_m1     = w_wd_ext - CMP_W'(1);
    assign w_learn_en  = (w_wd_ext != '0) && (w_wd_ext < CMP_W'(LOG_DEPTH))
                         && (w_fill_ext >= w_wd_ext);
    assign w_learn_sel = w_wd_m1[IDX_W-1:0];

    // ---- log of cells ----
    for (genvar k = 0; k < LOG_DEPTH; k++) begin : g_cell
        logic [PC_W-1:0]      w_in_pc;
        logic [ADDR_BITS-1:0] w_in_addr;
        logic [DW-1:0]        w_in_dlt;
        logic                 w_in_rdy;
        logic                 w_cell_hit;

        if (k == 0) begin : g_head
            assign w_in_pc   = i_access.access_pc;
            assign w_in_addr = w_new_addr;
            assign w_in_dlt  = '0;
            assign w_in_rdy  = 1'b0;
        end else begin : g_body
            assign w_in_pc   = w_pc[k-1];
            assign w_in_addr = w_addr[k-1];
            assign w_in_dlt  = w_dlt[k-1];
            assign w_in_rdy  = w_rdy[k-1];
        end

        pdw_cell #(
            .ADDR_BITS (ADDR_BITS),
            .IDX_W     (IDX_W),
            .CELL_IDX  (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (w_accept),
            .i_learn_en  (w_learn_en),
            .i_learn_sel (w_learn_sel),
            .i_new_addr  (w_new_addr),
            .i_query_pc  (r_q_pc),
            .i_pc        (w_in_pc),
            .i_addr      (w_in_addr),
            .i_delta     (w_in_dlt),
            .i_ready     (w_in_rdy),
            .o_pc        (w_pc[k]),
            .o_addr      (w_addr[k]),
            .o_delta     (w_dlt[k]),
            .o_ready     (w_rdy[k]),
            .o_hit       (w_cell_hit)
        );

        assign w_hit[k]       = w_cell_hit;
        assign w_hit_delta[k] = w_dlt[k];
    end

    for (genvar k = LOG_DEPTH; k < PAD_DEPTH; k++) begin : g_pad
        assign w_hit[k]       = 1'b0;
        assign w_hit_delta[k] = '0;
    end

    // ---- newest-match search ----
    for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
        pdw_sel #(
            .N  (GROUP_SIZE),
            .DW (DW)
        ) u_grp_sel (
            .i_clk   (i_clk),
            .i_en    (r_state == S_GROUP),
            .i_hit   (w_hit[g*GROUP_SIZE +: GROUP_SIZE]),
            .i_delta (w_hit_delta[g*GROUP_SIZE +: GROUP_SIZE]),
            .o_hit   (w_grp_hit[g]),
            .o_delta (w_grp_delta[g])
        );
    end

    pdw_sel #(
        .N  (NUM_GROUPS),
        .DW (DW)
    ) u_top_sel (
        .i_clk   (i_clk),
        .i_en    (r_state == S_SELECT),
        .i_hit   (w_grp_hit),
        .i_delta (w_grp_delta),
        .o_hit   (r_sel_hit),
        .o_delta (r_sel_delta)
    );

    // ---- target and range check ----
    assign w_sum      = $signed({2'b00, r_q_addr}) + $signed({r_sel_delta[DW-1], r_sel_delta});
    assign w_in_range = !w_sum[SW-1] && (CW'($unsigned(w_sum)) < CW'(r_limit));
    assign w_pf_valid = r_sel_hit && (r_sel_delta != '0) && w_in_range;

    // ---- control ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_GROUP;
                end
            end
            S_GROUP: begin
                n_state = S_SELECT;
            end
            S_SELECT: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                if (w_out_load) begin
                    n_state = w_accept ? S_GROUP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RST;
            r_wd        <= WD_RST;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MEMORY_LIMIT:    r_limit <= i_cfg_data[LIMIT_W-1:0];
                    CFG_WINDOW_DISTANCE: r_wd    <= i_cfg_data[WD_W-1:0];
                    default: ;
                endcase
            end
            if (w_accept && (r_fill != FILL_W'(LOG_DEPTH))) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if ((r_state == S_SUM) && w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_prefetch_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q_pc   <= i_access.access_pc;
            r_q_addr <= w_new_addr;
        end
        if ((r_state == S_SUM) && w_out_load) begin
            r_out.prefetch_valid <= w_pf_valid;
            r_out.prefetch_addr  <= w_pf_valid ? OUT_ADDR_W'($unsigned(w_sum)) : '0;
        end
    end

    assign o_prefetch_valid = r_out_valid;
    assign o_prefetch       = r_out;

endmodule

[sv/pdw_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdw_cell
// One log entry. Shifts towards older positions on each accepted word,
// learns its delta when selected, and flags a ready entry matching the query.
// ----------------------------------------------------------------------------
module pdw_cell import pdw_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int IDX_W     = 8,
    parameter int CELL_IDX  = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic                 i_learn_en,
    input  logic [IDX_W-1:0]     i_learn_sel,
    input  logic [ADDR_BITS-1:0] i_new_addr,
    input  logic [PC_W-1:0]      i_query_pc,
    input  logic [PC_W-1:0]      i_pc,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [ADDR_BITS:0]   i_delta,
    input  logic                 i_ready,
    output logic [PC_W-1:0]      o_pc,
    output logic [ADDR_BITS-1:0] o_addr,
    output logic [ADDR_BITS:0]   o_delta,
    output logic                 o_ready,
    output logic                 o_hit
);

    logic [PC_W-1:0]      r_pc;
    logic [ADDR_BITS-1:0] r_addr;
    logic [ADDR_BITS:0]   r_delta;
    logic                 r_ready;
    logic                 w_learn;
    logic [ADDR_BITS:0]   w_diff;

    assign w_learn = i_shift && i_learn_en && (i_learn_sel == IDX_W'(CELL_IDX));
    assign w_diff  = {1'b0, i_new_addr} - {1'b0, r_addr};

    assign o_pc    = r_pc;
    assign o_addr  = r_addr;
    assign o_delta = w_learn ? w_diff : r_delta;
    assign o_ready = r_ready | w_learn;
    assign o_hit   = r_ready && (r_pc == i_query_pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else if (i_shift) begin
            r_ready <= i_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pc    <= i_pc;
            r_addr  <= i_addr;
            r_delta <= i_delta;
        end
    end

endmodule

[sv/pdw_sel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdw_sel
// Registered priority select: lowest-indexed (newest) hit wins.
// ----------------------------------------------------------------------------
module pdw_sel #(
    parameter int N  = 16,
    parameter int DW = 33
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [N-1:0]         i_hit,
    input  logic [N-1:0][DW-1:0] i_delta,
    output logic                 o_hit,
    output logic [DW-1:0]        o_delta
);

    logic          w_hit;
    logic [DW-1:0] w_delta;

    always_comb begin
        w_hit   = 1'b0;
        w_delta = '0;
        for (int k = N - 1; k >= 0; k--) begin
            if (i_hit[k]) begin
                w_hit   = 1'b1;
                w_delta = i_delta[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit   <= w_hit;
            o_delta <= w_delta;
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PC-indexed delta window prefetcher. A directed
// table covers the state after reset, the address extremes, a zero delta and
// both out-of-range targets. Randomised phases follow, each with its own
// memory limit and window distance, the edge settings among them. Every
// accepted access word is run through a local model of the access log, and
// each prefetch word is compared with the oldest expected word. Both handshakes
// idle at random, but for the calm phases.
// ----------------------------------------------------------------------------
module tb_top;
    import pdw_pkg::*;

    localparam int N_DIR       = 24;
    localparam int N_PHASE     = 8;
    localparam int PHASE_WORDS = 178;
    localparam int N_STREAM    = 6;
    localparam int RING        = 256;

    typedef struct packed {
        logic [PC_W-1:0]       pc;
        logic [IN_ADDR_W-1:0]  addr;
        logic                  typed;
        logic                  exp_valid;
        logic [OUT_ADDR_W-1:0] exp_addr;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_MEMORY_LIMIT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_access_valid = 1'b0;
    logic                  o_access_ready;
    t_access_word          i_access = '0;
    logic                  o_prefetch_valid;
    logic                  i_prefetch_ready = 1'b0;
    t_prefetch_word        o_prefetch;

    // access log model
    logic [PC_W-1:0]      log_pc    [RING];
    logic [IN_ADDR_W-1:0] log_addr  [RING];
    longint               log_delta [RING];
    bit                   log_ready [RING];
    logic [7:0]           log_head;
    int                   log_fill;
    logic [LIMIT_W-1:0]   mem_limit;
    logic [WD_W-1:0]      win_dist;

    t_prefetch_word pending_prefetch[$];
    int             n_fail = 0;
    bit             calm = 1'b0;

    // access streams of the current phase
    logic [PC_W-1:0]      strm_pc     [N_STREAM];
    logic [IN_ADDR_W-1:0] strm_addr   [N_STREAM];
    logic [IN_ADDR_W-1:0] strm_stride [N_STREAM];
    int                   strm_cur = 0;

    t_dir_row dir_rows [N_DIR] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0400, 32'h0000_1080, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0400, 32'h0000_10C0, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0400, 32'h0000_1100, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0400, 32'h0000_1140, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0400, 32'h0000_1180, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0400, 32'h0000_11C0, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0400, 32'h0000_1200, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0400, 32'h0000_1240, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0000, 32'h0000_0010, 1'b1, 1'b1, 32'h20},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0400, 32'h0000_1080, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0400, 32'hFFFF_FFF0, 1'b1, 1'b0, 32'h0},
        '{32'h0000_0400, 32'h0000_1140, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0400, 32'h0000_1180, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0400, 32'h0000_11C0, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0400, 32'h0000_1200, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0400, 32'h0000_1240, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0400, 32'h0000_1280, 1'b0, 1'b0, 32'h0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0}
    };

    pc_delta_window_prefetcher_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_access_valid   (i_access_valid),
        .o_access_ready   (o_access_ready),
        .i_access         (i_access),
        .o_prefetch_valid (o_prefetch_valid),
        .i_prefetch_ready (i_prefetch_ready),
        .o_prefetch       (o_prefetch)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_prefetch_word predict_prefetch(input t_access_word w);
        logic [7:0]     slot;
        bit             hit;
        longint         delta;
        longint         sum;
        t_prefetch_word res;
        res   = '0;
        hit   = 1'b0;
        delta = 0;
        if (log_fill >= int'(win_dist)) begin
            slot = log_head - win_dist;
            log_delta[slot] = longint'({32'h0, w.access_addr}) - longint'({32'h0, log_addr[slot]});
            log_ready[slot] = 1'b1;
        end
        log_pc[log_head]    = w.access_pc;
        log_addr[log_head]  = w.access_addr;
        log_delta[log_head] = 0;
        log_ready[log_head] = 1'b0;
        log_head = log_head + 8'd1;
        if (log_fill < RING)
            log_fill++;
        for (int i = 1; i <= log_fill && !hit; i++) begin
            slot = log_head - 8'(i);
            if (log_ready[slot] && log_pc[slot] == w.access_pc) begin
                hit   = 1'b1;
                delta = log_delta[slot];
            end
        end
        if (hit && delta != 0) begin
            sum = longint'({32'h0, w.access_addr}) + delta;
            if (sum >= 0 && sum < longint'({32'h0, mem_limit})) begin
                res.prefetch_valid = 1'b1;
                res.prefetch_addr  = sum[OUT_ADDR_W-1:0];
            end
        end
        return res;
    endfunction

    function automatic logic [IN_ADDR_W-1:0] near_addr();
        longint span;
        longint v;
        span = (mem_limit == 0) ? 64 : longint'({32'h0, mem_limit});
        v = longint'({32'h0, $urandom}) % (span + span / 4 + 1);
        return v[IN_ADDR_W-1:0];
    endfunction

    function automatic logic [IN_ADDR_W-1:0] pick_stride();
        case ($urandom_range(0, 7))
            0:       return 32'd1;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd4;
            3:       return -32'd64;
            4:       return 32'd64;
            5:       return (mem_limit >> 4) + 32'd1;
            6:       return $urandom;
            default: return 32'd0;
        endcase
    endfunction

    function automatic void new_stream(input int k);
        strm_addr[k]   = near_addr();
        strm_stride[k] = pick_stride();
    endfunction

    function automatic t_access_word next_access();
        int           r;
        t_access_word w;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            if ($urandom_range(0, 4) == 0)
                strm_cur = $urandom_range(0, N_STREAM - 1);
            w.access_pc   = strm_pc[strm_cur];
            w.access_addr = strm_addr[strm_cur];
            strm_addr[strm_cur] = strm_addr[strm_cur] + strm_stride[strm_cur];
            if ($urandom_range(0, 39) == 0)
                new_stream(strm_cur);
        end else if (r < 90) begin
            w.access_pc   = strm_pc[$urandom_range(0, N_STREAM - 1)];
            w.access_addr = near_addr();
        end else begin
            w.access_pc = $urandom;
            case ($urandom_range(0, 2))
                0:       w.access_addr = '0;
                1:       w.access_addr = '1;
                default: w.access_addr = $urandom;
            endcase
        end
        return w;
    endfunction

    task automatic send_word(input t_access_word w, input bit typed, input t_prefetch_word fixed);
        int             gap;
        t_prefetch_word pred;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_access_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_access_valid <= 1'b1;
        i_access       <= w;
        @(posedge i_clk);
        while (o_access_ready !== 1'b1)
            @(posedge i_clk);
        pred = predict_prefetch(w);
        pending_prefetch.push_back(typed ? fixed : pred);
    endtask

    task automatic drain();
        i_access_valid <= 1'b0;
        while (pending_prefetch.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [LIMIT_W-1:0] lim, input logic [WD_W-1:0] wd);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MEMORY_LIMIT;
        i_cfg_data <= lim;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_WINDOW_DISTANCE;
        i_cfg_data <= CFG_DATA_W'(wd);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        mem_limit = lim;
        win_dist  = wd;
    endtask

    // result side
    initial begin
        int             stall;
        t_prefetch_word got;
        t_prefetch_word want;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_prefetch_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_prefetch_ready <= 1'b1;
            @(posedge i_clk);
            while (o_prefetch_valid !== 1'b1)
                @(posedge i_clk);
            got = o_prefetch;
            if (pending_prefetch.size() == 0) begin
                n_fail++;
                $display("%0t: unexpected prefetch word, expected none, got valid=%0b addr=%h",
                         $time, got.prefetch_valid, got.prefetch_addr);
            end else begin
                want = pending_prefetch.pop_front();
                if (got.prefetch_valid !== want.prefetch_valid ||
                    got.prefetch_addr !== want.prefetch_addr) begin
                    n_fail++;
                    $display("%0t: prefetch mismatch, expected valid=%0b addr=%h, %s%0b addr=%h",
                             $time, want.prefetch_valid, want.prefetch_addr, "got valid=",
                             got.prefetch_valid, got.prefetch_addr);
                end
            end
        end
    end

    // stimulus
    initial begin
        logic [LIMIT_W-1:0] lim;
        logic [WD_W-1:0]    wd;
        int                 n;
        t_access_word       w;
        t_prefetch_word     fixed;
        for (int i = 0; i < RING; i++) begin
            log_pc[i]    = '0;
            log_addr[i]  = '0;
            log_delta[i] = 0;
            log_ready[i] = 1'b0;
        end
        log_head  = '0;
        log_fill  = 0;
        mem_limit = LIMIT_RST;
        win_dist  = WD_RST;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings are in force for the table
        for (int k = 0; k < N_DIR; k++) begin
            w.access_pc          = dir_rows[k].pc;
            w.access_addr        = dir_rows[k].addr;
            fixed.prefetch_valid = dir_rows[k].exp_valid;
            fixed.prefetch_addr  = dir_rows[k].exp_addr;
            send_word(w, dir_rows[k].typed, fixed);
        end

        for (int p = 0; p < N_PHASE; p++) begin
            drain();
            case (p)
                0: begin lim = '1;                          wd = 8'd255; end
                1: begin lim = 32'd1;                       wd = 8'd1;   end
                2: begin lim = '0;                          wd = 8'd3;   end
                3: begin lim = $urandom_range(256, 65535);  wd = 8'd0;   end
                4: begin lim = $urandom;                    wd = WD_W'($urandom_range(1, 255)); end
                5: begin lim = 32'h8000_0000;               wd = 8'd2;   end
                6: begin lim = $urandom_range(1, 4096);     wd = WD_W'($urandom_range(1, 16)); end
                default: begin lim = '1;                    wd = WD_RST; end
            endcase
            write_regs(lim, wd);
            calm = (p == 3 || p == 6);
            for (int k = 0; k < N_STREAM; k++) begin
                strm_pc[k] = (k == 0 && p[0]) ? '1 : $urandom;
                new_stream(k);
            end
            for (int k = 0; k < PHASE_WORDS; k++)
                send_word(next_access(), 1'b0, '0);
        end

        i_access_valid <= 1'b0;
        n = 0;
        while (pending_prefetch.size() != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (20) @(posedge i_clk);
        if (pending_prefetch.size() != 0) begin
            n_fail++;
            $display("%0t: %0d prefetch words never arrived", $time, pending_prefetch.size());
        end
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
sv/pdw_pkg.sv
sv/pdw_cell.sv
sv/pdw_sel.sv
sv/pc_delta_window_prefetcher_unit.sv
tb/sv/tb_top.sv
